// ----- sv/i2cms_pkg.sv -----
`default_nettype none
package i2cms_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 3;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // entry points of the microprogram
    localparam logic [ADDR_W-1:0] EP_START  = 5'd0;
    localparam logic [ADDR_W-1:0] EP_STOP   = 5'd4;
    localparam logic [ADDR_W-1:0] EP_WRITE  = 5'd7;
    localparam logic [ADDR_W-1:0] EP_READ   = 5'd14;
    localparam logic [ADDR_W-1:0] LAST_ADDR = 5'd19;

    localparam logic [CNT_W-1:0] BIT_CNT_INIT = 3'd7;

    typedef enum logic [1:0] {
        SCL_KEEP = 2'd0,
        SCL_LO   = 2'd1,
        SCL_HI   = 2'd2
    } scl_op_t;

    typedef enum logic [2:0] {
        SDA_KEEP = 3'd0,
        SDA_LO   = 3'd1,
        SDA_HI   = 3'd2,
        SDA_BIT  = 3'd3,
        SDA_NACK = 3'd4
    } sda_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT    = 2'd0,
        SEQ_LOOP    = 2'd1,
        SEQ_STOP_BR = 2'd2,
        SEQ_END     = 2'd3
    } seq_op_t;

    typedef struct packed {
        scl_op_t           scl;
        sda_op_t           sda;
        logic              sample;
        logic              shift;
        seq_op_t           seq;
        logic [ADDR_W-1:0] target;
    } ucode_t;

    function automatic ucode_t uword(scl_op_t scl, sda_op_t sda, logic sample, logic shift,
                                     seq_op_t seq, logic [ADDR_W-1:0] target);
        ucode_t w;
        w.scl    = scl;
        w.sda    = sda;
        w.sample = sample;
        w.shift  = shift;
        w.seq    = seq;
        w.target = target;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(logic [ADDR_W-1:0] addr);
        ucode_t w;
        unique case (addr)
            // start condition
            5'd0:    w = uword(SCL_KEEP, SDA_HI,   1'b0, 1'b0, SEQ_NEXT,    EP_START);
            5'd1:    w = uword(SCL_HI,   SDA_KEEP, 1'b0, 1'b0, SEQ_NEXT,    EP_START);
            5'd2:    w = uword(SCL_KEEP, SDA_LO,   1'b0, 1'b0, SEQ_NEXT,    EP_START);
            5'd3:    w = uword(SCL_LO,   SDA_KEEP, 1'b0, 1'b0, SEQ_END,     EP_START);
            // stop condition
            5'd4:    w = uword(SCL_KEEP, SDA_LO,   1'b0, 1'b0, SEQ_NEXT,    EP_STOP);
            5'd5:    w = uword(SCL_HI,   SDA_KEEP, 1'b0, 1'b0, SEQ_NEXT,    EP_STOP);
            5'd6:    w = uword(SCL_KEEP, SDA_HI,   1'b0, 1'b0, SEQ_END,     EP_STOP);
            // write byte, MSB first, then ack slot
            5'd7:    w = uword(SCL_KEEP, SDA_BIT,  1'b0, 1'b0, SEQ_NEXT,    EP_WRITE);
            5'd8:    w = uword(SCL_HI,   SDA_KEEP, 1'b0, 1'b0, SEQ_NEXT,    EP_WRITE);
            5'd9:    w = uword(SCL_LO,   SDA_KEEP, 1'b0, 1'b1, SEQ_LOOP,    EP_WRITE);
            5'd10:   w = uword(SCL_KEEP, SDA_LO,   1'b0, 1'b0, SEQ_NEXT,    EP_WRITE);
            5'd11:   w = uword(SCL_KEEP, SDA_HI,   1'b0, 1'b0, SEQ_NEXT,    EP_WRITE);
            5'd12:   w = uword(SCL_HI,   SDA_KEEP, 1'b1, 1'b0, SEQ_NEXT,    EP_WRITE);
            5'd13:   w = uword(SCL_LO,   SDA_KEEP, 1'b0, 1'b0, SEQ_STOP_BR, EP_STOP);
            // read byte, then ack or nack
            5'd14:   w = uword(SCL_HI,   SDA_KEEP, 1'b1, 1'b0, SEQ_NEXT,    EP_READ);
            5'd15:   w = uword(SCL_LO,   SDA_KEEP, 1'b0, 1'b0, SEQ_LOOP,    EP_READ);
            5'd16:   w = uword(SCL_KEEP, SDA_NACK, 1'b0, 1'b0, SEQ_NEXT,    EP_READ);
            5'd17:   w = uword(SCL_HI,   SDA_KEEP, 1'b0, 1'b0, SEQ_NEXT,    EP_READ);
            5'd18:   w = uword(SCL_LO,   SDA_KEEP, 1'b0, 1'b0, SEQ_NEXT,    EP_READ);
            5'd19:   w = uword(SCL_KEEP, SDA_HI,   1'b0, 1'b0, SEQ_STOP_BR, EP_STOP);
            default: w = uword(SCL_KEEP, SDA_KEEP, 1'b0, 1'b0, SEQ_END,     EP_START);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- sv/i2cms_cmd_if.sv -----
`default_nettype none
interface i2cms_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] write_byte;
    logic       nack_last;
    logic       stop_after;
    logic [8:0] bus_samples;

    modport source (output valid, opcode, write_byte, nack_last, stop_after, bus_samples,
                    input ready);
    modport sink (input valid, opcode, write_byte, nack_last, stop_after, bus_samples,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/i2cms_evt_if.sv -----
`default_nettype none
interface i2cms_evt_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sample_here;
    logic [7:0] read_byte;
    logic       got_nack;
    logic       last_event;

    modport source (output valid, scl_level, sda_level, sample_here, read_byte, got_nack,
                    last_event, input ready);
    modport sink (input valid, scl_level, sda_level, sample_here, read_byte, got_nack,
                  last_event, output ready);
endinterface
`default_nettype wire

// ----- sv/i2cms_sequencer.sv -----
`default_nettype none
module i2cms_sequencer
    import i2cms_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] opcode,
    input  wire logic       stop_after,
    input  wire logic       ack_bit,
    input  wire logic       advance,
    output logic            busy,
    output logic            last,
    output ucode_t          ctrl
);

    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              stop_reg, stop_next;

    assign ctrl = ucode_rom(pc_reg);
    assign busy = busy_reg;
    assign last = (ctrl.seq == SEQ_END) || ((ctrl.seq == SEQ_STOP_BR) && !stop_reg);

    always_comb
    begin
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        stop_next = stop_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = BIT_CNT_INIT;
            unique case (opcode)
                OP_START:
                begin
                    pc_next   = EP_START;
                    stop_next = 1'b0;
                end
                OP_STOP:
                begin
                    pc_next   = EP_STOP;
                    stop_next = 1'b0;
                end
                OP_WRITE:
                begin
                    pc_next   = EP_WRITE;
                    stop_next = stop_after | ack_bit;
                end
                default:
                begin
                    pc_next   = EP_READ;
                    stop_next = stop_after;
                end
            endcase
        end
        else if (advance)
        begin
            unique case (ctrl.seq)
                SEQ_NEXT: pc_next = pc_reg + 5'd1;
                SEQ_LOOP:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - 3'd1;
                        pc_next  = ctrl.target;
                    end
                    else
                    begin
                        pc_next = pc_reg + 5'd1;
                    end
                end
                SEQ_STOP_BR:
                begin
                    if (stop_reg)
                    begin
                        pc_next   = ctrl.target;
                        stop_next = 1'b0;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= EP_START;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            stop_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            stop_reg <= stop_next;
        end
    end

`ifndef ASSERT_OFF
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= LAST_ADDR)
        else $error("step counter beyond program");
    a_end_drops_busy: assert property (@(posedge clk) disable iff (!rst_n)
        advance && busy_reg && last |=> !busy_reg)
        else $error("busy held after final event");
    a_busy_fall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(advance && last))
        else $error("busy dropped without final event");
    a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && advance && !start && ctrl.seq == SEQ_LOOP && cnt_reg == '0
        |=> pc_reg == $past(pc_reg) + 5'd1)
        else $error("bit loop did not fall through");
`endif

endmodule
`default_nettype wire

// ----- sv/i2cms_datapath.sv -----
`default_nettype none
module i2cms_datapath
    import i2cms_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] opcode,
    input  wire logic [7:0] write_byte,
    input  wire logic       nack_last,
    input  wire logic [8:0] bus_samples,
    input  wire logic       advance,
    input  wire logic       last,
    input  wire ucode_t     ctrl,
    output logic            slot_free,
    i2cms_evt_if.source     evt
);

    logic [BYTE_W-1:0] shift_reg;
    logic [BYTE_W-1:0] rbyte_reg;
    logic              nackl_reg;
    logic              gnack_reg;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              ov_reg;
    logic              o_scl_reg, o_sda_reg, o_sample_reg, o_nack_reg, o_last_reg;
    logic [BYTE_W-1:0] o_byte_reg;

    assign slot_free = !ov_reg || evt.ready;

    always_comb
    begin
        unique case (ctrl.scl)
            SCL_LO:  scl_next = 1'b0;
            SCL_HI:  scl_next = 1'b1;
            default: scl_next = scl_reg;
        endcase
        unique case (ctrl.sda)
            SDA_LO:   sda_next = 1'b0;
            SDA_HI:   sda_next = 1'b1;
            SDA_BIT:  sda_next = shift_reg[BYTE_W-1];
            SDA_NACK: sda_next = nackl_reg;
            default:  sda_next = sda_reg;
        endcase
    end

    // command operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= write_byte;
            nackl_reg <= nack_last;
            rbyte_reg <= (opcode == OP_READ) ? bus_samples[8:1] : '0;
            gnack_reg <= (opcode == OP_WRITE) ? bus_samples[0] : 1'b0;
        end
        else if (advance && ctrl.shift)
        begin
            shift_reg <= {shift_reg[BYTE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg <= 1'b1;
            sda_reg <= 1'b1;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                scl_reg <= scl_next;
                sda_reg <= sda_next;
                ov_reg  <= 1'b1;
            end
            else if (evt.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o_scl_reg    <= scl_next;
            o_sda_reg    <= sda_next;
            o_sample_reg <= ctrl.sample;
            o_last_reg   <= last;
            o_byte_reg   <= last ? rbyte_reg : '0;
            o_nack_reg   <= last ? gnack_reg : 1'b0;
        end
    end

    assign evt.valid       = ov_reg;
    assign evt.scl_level   = o_scl_reg;
    assign evt.sda_level   = o_sda_reg;
    assign evt.sample_here = o_sample_reg;
    assign evt.read_byte   = o_byte_reg;
    assign evt.got_nack    = o_nack_reg;
    assign evt.last_event  = o_last_reg;

endmodule
`default_nettype wire

// ----- sv/i2c_master_byte_sequencer.sv -----
`default_nettype none
// The command transfer loads the step counter and busy flag; the first line event is then
// registered into the event output register. One event per cycle while the output is taken;
// the microprogram step counter sets the sequence of events that each command produces.
// A stalled event output holds the step counter; the next command is taken once the
// final event is loaded, while it still waits to be taken.
// Reset: both lines released high, no command in flight, output empty.
module i2c_master_byte_sequencer
    import i2cms_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    i2cms_cmd_if.sink   cmd,
    i2cms_evt_if.source evt
);

    logic   start;
    logic   busy;
    logic   last;
    logic   slot_free;
    logic   advance;
    ucode_t ctrl;

    // take a command only when no program is running
    assign cmd.ready = !busy;
    assign start     = cmd.valid && !busy;

    // step the program whenever the output register can take the event
    assign advance = busy && slot_free;

    // step counter, bit loop counter and stop branch condition
    i2cms_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .opcode     (cmd.opcode),
        .stop_after (cmd.stop_after),
        .ack_bit    (cmd.bus_samples[0]),
        .advance    (advance),
        .busy       (busy),
        .last       (last),
        .ctrl       (ctrl)
    );

    // line levels, shift register, sampled bytes and event output register
    i2cms_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (cmd.opcode),
        .write_byte  (cmd.write_byte),
        .nack_last   (cmd.nack_last),
        .bus_samples (cmd.bus_samples),
        .advance     (advance),
        .last        (last),
        .ctrl        (ctrl),
        .slot_free   (slot_free),
        .evt         (evt)
    );

endmodule
`default_nettype wire
